// ----- hdl/dpr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dpr_pkg;

  // Default pixel coordinate width (column and row).
  localparam int COORD_BITS_DEF = 12;

  // Register widths.
  localparam int BASE_W  = 32;
  localparam int FOCAL_W = 20;
  localparam int MIN_W   = 12;
  localparam int RANGE_W = 31;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 3;

  // Field widths.
  localparam int DISP_W  = 16;
  localparam int COLOR_W = 8;
  localparam int POS_W   = 32;

  // Divider geometry: divisor magnitude, multiplier operand, quotient bits.
  localparam int DEN_W = 20;
  localparam int MUL_W = 32;
  localparam int QUO_W = 33;

  // Divider stages: round, range check, one stage per quotient bit, saturate.
  localparam int DIV_LAT  = QUO_W + 3;
  // Whole pipe: operand stage, multiply stage, divider.
  localparam int PIPE_LAT = DIV_LAT + 2;

  localparam logic [POS_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [POS_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASELINE  = 3'd0,
    REG_FOCAL     = 3'd1,
    REG_CENTER_X  = 3'd2,
    REG_CENTER_Y  = 3'd3,
    REG_MIN_DISP  = 3'd4,
    REG_FAR_DEPTH = 3'd5
  } cfg_reg_t;

  // Divider control: divisor magnitude and result sign.
  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic             neg;
  } div_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/dpr_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pipelined rounded, saturated divider: one restoring step per stage.
module dpr_div import dpr_pkg::*; #(
  parameter int NumW = 53
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [NumW-2:0]         prod,
  input  wire div_ctl_t                ctl,
  output logic signed [POS_W-1:0]      quo
);

  // Round stage.
  logic [NumW-1:0]  rnd_n;
  div_ctl_t         rnd_ctl;

  // Bit stages; index 0 is the range-check stage.
  logic [DEN_W-1:0] rem  [QUO_W+1];
  logic [QUO_W-1:0] low  [QUO_W+1];
  logic [QUO_W-1:0] qbit [QUO_W+1];
  div_ctl_t         sctl [QUO_W+1];
  logic             ovf  [QUO_W+1];
  logic             zz   [QUO_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rnd_n   <= {1'b0, prod} + NumW'(ctl.den >> 1);
      rnd_ctl <= ctl;
    end
  end

  // Quotient of 2^QUO_W or more saturates anyway; zero over zero gives zero.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= DEN_W'(rnd_n >> QUO_W);
      low[0]  <= rnd_n[QUO_W-1:0];
      qbit[0] <= '0;
      sctl[0] <= rnd_ctl;
      ovf[0]  <= (rnd_n >> QUO_W) >= NumW'(rnd_ctl.den);
      zz[0]   <= (rnd_ctl.den == '0) && (rnd_n == '0);
    end
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    logic [DEN_W:0] trial;
    logic           fits;

    assign trial = {rem[i], low[i][QUO_W-1]};
    assign fits  = trial >= {1'b0, sctl[i].den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= fits ? DEN_W'(trial - {1'b0, sctl[i].den}) : DEN_W'(trial);
        low[i+1]  <= {low[i][QUO_W-2:0], 1'b0};
        qbit[i+1] <= {qbit[i][QUO_W-2:0], fits};
        sctl[i+1] <= sctl[i];
        ovf[i+1]  <= ovf[i];
        zz[i+1]   <= zz[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (zz[QUO_W]) begin
        quo <= '0;
      end else if (ovf[QUO_W]) begin
        quo <= sctl[QUO_W].neg ? SAT_NEG : SAT_POS;
      end else if (sctl[QUO_W].neg) begin
        quo <= (qbit[QUO_W] > {1'b0, SAT_NEG}) ? SAT_NEG
                                               : POS_W'(QUO_W'(0) - qbit[QUO_W]);
      end else begin
        quo <= (qbit[QUO_W] > {1'b0, SAT_POS}) ? SAT_POS : qbit[QUO_W][POS_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/disparity_to_point_reprojection_unit.sv -----
// Disparity to 3D point reprojection.
// Pixel channel: column, row, disparity (signed Q12.4) and colour arrive as
// one beat, taken on a rising edge with pixel_valid high and pixel_stall low.
// Result channel: point_valid, pos_x/pos_y/pos_z (signed Q16.16, saturated)
// and colour, offered with result_valid and taken when result_stall is low.
// Every pixel beat yields exactly one result beat, in order.
// Path from pixel acceptance to result_valid: operand stage, multiply stage,
// 36-stage divider. Throughput: one beat per cycle while nothing stalls; the
// bound is the divider, one quotient bit per stage.
// Configuration: cfg_write with cfg_index and cfg_data writes one register;
// write only while the pipe holds no beats. Reset (rst, synchronous) clears
// the registers to their defaults (focal_length = 1.0) and empties the pipe.
// Stall: while result_valid is high and result_stall is high, the whole pipe
// freezes and pixel_stall is raised; no beat is lost or repeated, and the
// offered result holds. Points below the disparity floor come out with
// point_valid low and all position and colour fields zero.
`timescale 1ns / 1ps
`default_nettype none

module disparity_to_point_reprojection_unit import dpr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // configuration
  input  wire logic                    cfg_write,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data,
  // pixel channel
  input  wire logic                    pixel_valid,
  output logic                         pixel_stall,
  input  wire logic [COORD_BITS-1:0]   column,
  input  wire logic [COORD_BITS-1:0]   row,
  input  wire logic signed [DISP_W-1:0] disparity,
  input  wire logic [COLOR_W-1:0]      red_in,
  input  wire logic [COLOR_W-1:0]      green_in,
  input  wire logic [COLOR_W-1:0]      blue_in,
  // result channel
  output logic                         result_valid,
  input  wire logic                    result_stall,
  output logic                         point_valid,
  output logic signed [POS_W-1:0]      pos_x,
  output logic signed [POS_W-1:0]      pos_y,
  output logic signed [POS_W-1:0]      pos_z,
  output logic [COLOR_W-1:0]           red_out,
  output logic [COLOR_W-1:0]           green_out,
  output logic [COLOR_W-1:0]           blue_out
);

  // Coordinate in Q.4 and the magnitude width of (u - cx) and focal length.
  localparam int UW    = COORD_BITS + 4;
  localparam int MAG_W = (UW > DEN_W) ? UW : DEN_W;
  localparam int NUM_W = MAG_W + MUL_W + 1;

  typedef struct packed {
    logic               ok;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } side_t;

  // Configuration registers.
  logic signed [BASE_W-1:0] baseline;
  logic [FOCAL_W-1:0]       focal_length;
  logic [FOCAL_W-1:0]       center_x;
  logic [FOCAL_W-1:0]       center_y;
  logic signed [MIN_W-1:0]  disp_floor;
  logic [RANGE_W-1:0]       far_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline      <= '0;
      focal_length  <= FOCAL_W'(16);
      center_x      <= '0;
      center_y      <= '0;
      disp_floor    <= '0;
      far_depth     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BASELINE:  baseline      <= cfg_data[BASE_W-1:0];
        REG_FOCAL:     focal_length  <= cfg_data[FOCAL_W-1:0];
        REG_CENTER_X:  center_x      <= cfg_data[FOCAL_W-1:0];
        REG_CENTER_Y:  center_y      <= cfg_data[FOCAL_W-1:0];
        REG_MIN_DISP:  disp_floor    <= cfg_data[MIN_W-1:0];
        REG_FAR_DEPTH: far_depth     <= cfg_data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // One enable for the whole pipe: freeze only when the offered result is held.
  logic en;
  assign en          = !(result_valid && result_stall);
  assign pixel_stall = !en;

  // Valid bits and sideband travel together down the pipe.
  logic [PIPE_LAT-1:0] vld;
  side_t               side [PIPE_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], pixel_valid};
    end
  end

  // ---------------------------------------------------------------------
  // Operand stage: range check, offsets from the principal point, signs and
  // magnitudes, choice of the baseline path or the zero-disparity path.
  // ---------------------------------------------------------------------
  logic signed [MAG_W:0]     du_s, dv_s;
  logic signed [DISP_W-1:0]  min_q;
  logic                      disp_ok, disp_zero;
  logic [MUL_W-1:0]          base_mag;
  logic [DISP_W-1:0]         disp_mag;

  assign du_s = $signed({{(MAG_W+1-UW){1'b0}}, column, 4'b0000})
              - $signed({{(MAG_W+1-FOCAL_W){1'b0}}, center_x});
  assign dv_s = $signed({{(MAG_W+1-UW){1'b0}}, row, 4'b0000})
              - $signed({{(MAG_W+1-FOCAL_W){1'b0}}, center_y});
  assign min_q     = {disp_floor, 4'b0000};
  assign disp_ok   = disparity >= min_q;
  assign disp_zero = disparity == '0;
  assign base_mag  = baseline[BASE_W-1] ? MUL_W'(-baseline) : MUL_W'(baseline);
  assign disp_mag  = disparity[DISP_W-1] ? DISP_W'(-disparity) : DISP_W'(disparity);

  logic [MAG_W-1:0] op_du, op_dv, op_f;
  logic             op_du_neg, op_dv_neg;
  logic [MUL_W-1:0] op_m;
  logic             op_m_neg;
  div_ctl_t         op_den;

  always_ff @(posedge clk) begin
    if (en) begin
      op_du     <= du_s[MAG_W] ? MAG_W'(-du_s) : du_s[MAG_W-1:0];
      op_dv     <= dv_s[MAG_W] ? MAG_W'(-dv_s) : dv_s[MAG_W-1:0];
      op_du_neg <= du_s[MAG_W];
      op_dv_neg <= dv_s[MAG_W];
      op_f      <= MAG_W'(focal_length);
      // A rejected point gets a zero numerator, so every quotient is zero.
      op_m      <= !disp_ok ? '0 : (disp_zero ? MUL_W'(far_depth) : base_mag);
      // Numerator uses -baseline: on the baseline path its sign is set unless baseline is negative.
      op_m_neg  <= !disp_zero && !baseline[BASE_W-1];
      op_den.den <= disp_zero ? focal_length : DEN_W'(disp_mag);
      op_den.neg <= !disp_zero && disparity[DISP_W-1];
      side[0].ok    <= disp_ok;
      side[0].red   <= disp_ok ? red_in   : '0;
      side[0].green <= disp_ok ? green_in : '0;
      side[0].blue  <= disp_ok ? blue_in  : '0;
    end
  end

  // ---------------------------------------------------------------------
  // Multiply stage: three magnitude products, result signs.
  // ---------------------------------------------------------------------
  logic [NUM_W-2:0] prod_x, prod_y, prod_z;
  div_ctl_t         ctl_x, ctl_y, ctl_z;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x    <= (NUM_W-1)'(op_du * op_m);
      prod_y    <= (NUM_W-1)'(op_dv * op_m);
      prod_z    <= (NUM_W-1)'(op_f * op_m);
      ctl_x.den <= op_den.den;
      ctl_y.den <= op_den.den;
      ctl_z.den <= op_den.den;
      ctl_x.neg <= op_du_neg ^ op_m_neg ^ op_den.neg;
      ctl_y.neg <= op_dv_neg ^ op_m_neg ^ op_den.neg;
      ctl_z.neg <= op_m_neg ^ op_den.neg;
    end
  end

  // Sideband delay line to match the divider.
  for (genvar i = 1; i < PIPE_LAT; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        side[i] <= side[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Dividers: rounded to nearest, ties away from zero, saturated.
  // ---------------------------------------------------------------------
  dpr_div #(.NumW(NUM_W)) u_div_x (
    .clk  (clk),
    .en   (en),
    .prod (prod_x),
    .ctl  (ctl_x),
    .quo  (pos_x)
  );

  dpr_div #(.NumW(NUM_W)) u_div_y (
    .clk  (clk),
    .en   (en),
    .prod (prod_y),
    .ctl  (ctl_y),
    .quo  (pos_y)
  );

  dpr_div #(.NumW(NUM_W)) u_div_z (
    .clk  (clk),
    .en   (en),
    .prod (prod_z),
    .ctl  (ctl_z),
    .quo  (pos_z)
  );

  assign result_valid = vld[PIPE_LAT-1];
  assign point_valid  = side[PIPE_LAT-1].ok;
  assign red_out      = side[PIPE_LAT-1].red;
  assign green_out    = side[PIPE_LAT-1].green;
  assign blue_out     = side[PIPE_LAT-1].blue;

endmodule

`default_nettype wire

// ----- hdl/dpr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dpr_checker import dpr_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     pixel_stall,
  input wire logic                     result_valid,
  input wire logic                     result_stall,
  input wire logic                     point_valid,
  input wire logic signed [POS_W-1:0]  pos_x,
  input wire logic signed [POS_W-1:0]  pos_y,
  input wire logic signed [POS_W-1:0]  pos_z,
  input wire logic [COLOR_W-1:0]       red_out,
  input wire logic [COLOR_W-1:0]       green_out,
  input wire logic [COLOR_W-1:0]       blue_out
);

  // Reset empties the pipe.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result offered right after reset");

  // Rejected points carry nothing.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !point_valid) |->
      (pos_x == '0 && pos_y == '0 && pos_z == '0 &&
       red_out == '0 && green_out == '0 && blue_out == '0))
    else $error("rejected point with nonzero payload");

  // Backpressure only comes from a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (result_valid && result_stall))
    else $error("pixel channel stalled without a held result");

  // A held result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(pos_x) && $stable(pos_y) && $stable(pos_z) &&
       $stable(point_valid)))
    else $error("held result changed");

endmodule

bind disparity_to_point_reprojection_unit dpr_checker u_dpr_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_stall  (pixel_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .point_valid  (point_valid),
  .pos_x        (pos_x),
  .pos_y        (pos_y),
  .pos_z        (pos_z),
  .red_out      (red_out),
  .green_out    (green_out),
  .blue_out     (blue_out)
);

`default_nettype wire
